@@ design/cbe_pkg.sv @@
// cbe_pkg: shared widths, constants, register codes and pipeline types
// for the cubic Bezier point evaluator. No dependencies.
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int COORD_W        = 12;  // control/result coordinate width
  localparam int T_W            = 17;  // curve parameter width, Q0.16 plus the 1.0 bit
  localparam int FRAC_W         = 16;  // fraction bits of t
  localparam int MUL_CHUNK_W    = 32;  // slice width of the wide multiplies
  localparam int NUM_CTRL       = 4;   // control points held in registers
  localparam int NUM_POINTS_DEF = 4;   // cubic curve
  localparam int CFG_IDX_W      = 4;
  localparam int NUM_REGS       = 2 * NUM_CTRL;

  localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

  // reset coordinates, [point][0 = x, 1 = y]
  localparam logic [COORD_W-1:0] CTRL_RST [NUM_CTRL][2] = '{
    '{12'd200, 12'd200},
    '{12'd400, 12'd400},
    '{12'd600, 12'd450},
    '{12'd800, 12'd200}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL0_X = 4'd0,
    REG_CTRL0_Y = 4'd1,
    REG_CTRL1_X = 4'd2,
    REG_CTRL1_Y = 4'd3,
    REG_CTRL2_X = 4'd4,
    REG_CTRL2_Y = 4'd5,
    REG_CTRL3_X = 4'd6,
    REG_CTRL3_Y = 4'd7
  } cfg_reg_t;

  // forward control traveling with each beat between pipeline levels
  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] t;
  } pipe_fwd_t;

endpackage

@@ design/cbe_lerp_level.sv @@
// cbe_lerp_level: one de Casteljau level, three register stages
// (difference, sliced multiply by t, shift-add). Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_lerp_level
  import cbe_pkg::*;
#(
  parameter int NP   = NUM_POINTS_DEF,
  parameter int LVL  = 1,
  parameter int WMAX = COORD_W + FRAC_W * (NUM_POINTS_DEF - 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pipe_fwd_t       in_fwd,
  output logic            in_ready,
  input  logic [WMAX-1:0] in_pts  [2][NP],
  output pipe_fwd_t       out_fwd,
  input  logic            out_ready,
  output logic [WMAX-1:0] out_pts [2][NP]
);

  localparam int WI   = COORD_W + FRAC_W * (LVL - 1);  // exact input width
  localparam int WO   = WI + FRAC_W;                   // exact output width
  localparam int DW   = WI + 1;                        // signed difference
  localparam int CH   = MUL_CHUNK_W;
  localparam int NCH  = (DW + CH - 1) / CH;
  localparam int DXW  = NCH * CH;
  localparam int PW   = CH + T_W + 2;
  localparam int LW   = WO + PW + DXW;
  localparam int NOUT = NP - LVL;

  // u*a + t*b == (a << 16) + t*(b - a), since t + u == 1.0
  logic                  va_r, vb_r, vc_r;
  logic                  en_a, en_b, en_c;
  logic [T_W-1:0]        ta_r, tb_r, tc_r;
  logic [WI-1:0]         a_r   [2][NOUT];
  logic signed [DW-1:0]  d_r   [2][NOUT];
  logic signed [DW-1:0]  d_nxt [2][NOUT];
  logic [WI-1:0]         ab_r  [2][NOUT];
  logic signed [PW-1:0]  p_r   [2][NOUT][NCH];
  logic signed [PW-1:0]  p_nxt [2][NOUT][NCH];
  logic [WO-1:0]         s_r   [2][NOUT];
  logic [WO-1:0]         s_nxt [2][NOUT];

  assign en_c     = !vc_r || out_ready;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < NOUT; i++) begin
        d_nxt[ax][i] = $signed({1'b0, in_pts[ax][i+1][WI-1:0]})
                     - $signed({1'b0, in_pts[ax][i][WI-1:0]});
      end
    end
  end

  // low slices are unsigned, the top slice carries the sign
  always_comb begin
    logic signed [DXW-1:0] dx;
    logic signed [CH:0]    mc;
    logic signed [T_W:0]   tc;
    tc = $signed({1'b0, ta_r});
    dx = '0;
    mc = '0;
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < NOUT; i++) begin
        dx = {{(DXW-DW){d_r[ax][i][DW-1]}}, d_r[ax][i]};
        for (int j = 0; j < NCH; j++) begin
          if (j == NCH - 1) begin
            mc = $signed({dx[DXW-1], dx[j*CH +: CH]});
          end else begin
            mc = $signed({1'b0, dx[j*CH +: CH]});
          end
          p_nxt[ax][i][j] = mc * tc;
        end
      end
    end
  end

  // result is known to fit WO bits unsigned, so modular arithmetic is exact
  always_comb begin
    logic signed [LW-1:0] acc;
    acc = '0;
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < NOUT; i++) begin
        acc = $signed({{(LW-WO){1'b0}}, ab_r[ax][i], {FRAC_W{1'b0}}});
        for (int j = 0; j < NCH; j++) begin
          acc = acc + ($signed({{(LW-PW){p_r[ax][i][j][PW-1]}}, p_r[ax][i][j]})
                       <<< (CH * j));
        end
        s_nxt[ax][i] = acc[WO-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_fwd.valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_fwd.valid) begin
      ta_r <= in_fwd.t;
      for (int ax = 0; ax < 2; ax++) begin
        for (int i = 0; i < NOUT; i++) begin
          a_r[ax][i] <= in_pts[ax][i][WI-1:0];
          d_r[ax][i] <= d_nxt[ax][i];
        end
      end
    end
    if (en_b && va_r) begin
      tb_r <= ta_r;
      ab_r <= a_r;
      p_r  <= p_nxt;
    end
    if (en_c && vb_r) begin
      tc_r <= tb_r;
      s_r  <= s_nxt;
    end
  end

  assign out_fwd = '{valid: vc_r, t: tc_r};

  for (genvar ax = 0; ax < 2; ax++) begin : g_ax
    for (genvar i = 0; i < NP; i++) begin : g_pt
      if (i < NOUT) begin : g_live
        assign out_pts[ax][i] = WMAX'(s_r[ax][i]);
      end else begin : g_idle
        assign out_pts[ax][i] = '0;
      end
    end
  end

endmodule

@@ design/cubic_bezier_point_evaluator.sv @@
// cubic_bezier_point_evaluator: top level, control point registers,
// de Casteljau level pipeline and output register. Depends on cbe_pkg, cbe_lerp_level.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in_     | input     | in_valid/in_stall  | in_param_t[16:0] Q1.16
//  out_    | output    | out_valid/out_stall| out_point_x, out_point_y
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index[3:0], cfg_data[11:0]
//
//  One beat per clock sustained while out_stall stays low. There are three register
//  stages per de Casteljau level, set by the sliced multiply of the exact
//  difference by t, plus the output register.
//  rst_n (sync, active low) empties the pipeline and loads the default control
//  points. out_stall backs up stage by stage; bubbles are squeezed out, and
//  in_stall rises only when every stage holds a beat and the output is stalled.
//  cfg_ready is always high; writes are registered directly, indices above 7 are dropped.

module cubic_bezier_point_evaluator
  import cbe_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [T_W-1:0]       in_param_t,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   out_point_x,
  output logic [COORD_W-1:0]   out_point_y,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // exact width of the final level: 12 integer bits over 16 fraction bits per level
  localparam int WMAX = COORD_W + FRAC_W * (NUM_POINTS - 1);
  localparam int LAST = NUM_POINTS - 1;

  logic [COORD_W-1:0] ctrl_r [NUM_CTRL][2];

  // level k holds the (NUM_POINTS-k) points of de Casteljau level k
  pipe_fwd_t          lvl_fwd   [NUM_POINTS];
  logic               lvl_ready [NUM_POINTS];
  logic [WMAX-1:0]    lvl_pts   [NUM_POINTS][2][NUM_POINTS];

  logic               out_valid_r;
  logic               en_out;
  logic [COORD_W-1:0] pt_x_r, pt_y_r;

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= CTRL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CTRL0_X: ctrl_r[0][0] <= cfg_data;
        REG_CTRL0_Y: ctrl_r[0][1] <= cfg_data;
        REG_CTRL1_X: ctrl_r[1][0] <= cfg_data;
        REG_CTRL1_Y: ctrl_r[1][1] <= cfg_data;
        REG_CTRL2_X: ctrl_r[2][0] <= cfg_data;
        REG_CTRL2_Y: ctrl_r[2][1] <= cfg_data;
        REG_CTRL3_X: ctrl_r[3][0] <= cfg_data;
        REG_CTRL3_Y: ctrl_r[3][1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- level 0: control points, t clamped to 1.0 ----
  // points past the fourth reuse the fourth control point
  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_src
    localparam int SRC = (i < NUM_CTRL) ? i : NUM_CTRL - 1;
    assign lvl_pts[0][0][i] = WMAX'(ctrl_r[SRC][0]);
    assign lvl_pts[0][1][i] = WMAX'(ctrl_r[SRC][1]);
  end

  assign lvl_fwd[0] = '{valid: in_valid,
                        t:     (in_param_t > T_ONE) ? T_ONE : in_param_t};
  assign in_stall   = !lvl_ready[0];

  // ---- de Casteljau levels ----
  for (genvar k = 1; k < NUM_POINTS; k++) begin : g_lvl
    cbe_lerp_level #(
      .NP   (NUM_POINTS),
      .LVL  (k),
      .WMAX (WMAX)
    ) u_lvl (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_fwd    (lvl_fwd[k-1]),
      .in_ready  (lvl_ready[k-1]),
      .in_pts    (lvl_pts[k-1]),
      .out_fwd   (lvl_fwd[k]),
      .out_ready (lvl_ready[k]),
      .out_pts   (lvl_pts[k])
    );
  end

  // ---- output register: drop the 16*(NUM_POINTS-1) fraction bits ----
  assign en_out          = !out_valid_r || !out_stall;
  assign lvl_ready[LAST] = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= lvl_fwd[LAST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && lvl_fwd[LAST].valid) begin
      pt_x_r <= lvl_pts[LAST][0][0][WMAX-1 -: COORD_W];
      pt_y_r <= lvl_pts[LAST][1][0][WMAX-1 -: COORD_W];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = pt_x_r;
  assign out_point_y = pt_y_r;

endmodule

@@ design/cbe_checker.sv @@
// cbe_checker: port-level checks on the Bezier evaluator, plus the bind
// that attaches it to the top level. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_checker
  import cbe_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [COORD_W-1:0]   out_point_x,
  input logic [COORD_W-1:0]   out_point_y
);

  localparam int DEPTH = 3 * (NUM_POINTS - 1) + 1;
  localparam int CW    = $clog2(DEPTH + 2);

  logic          in_acc, out_acc;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cnt_nxt = cnt_r + CW'(in_acc) - CW'(out_acc);

  // beats inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) && $stable(out_point_y))
    else $error("result beat changed while stalled");

  // input backs up only when the whole pipe is full and the output stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && cnt_r == CW'(DEPTH))
    else $error("input stalled with room in the pipeline");

  // no result without a beat inside
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result beat with no input beat outstanding");

  // never more beats inside than pipeline slots
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("more beats in flight than pipeline stages");

endmodule

bind cubic_bezier_point_evaluator cbe_checker #(
  .NUM_POINTS (NUM_POINTS)
) u_cbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_point_x (out_point_x),
  .out_point_y (out_point_y)
);

@@ dv/tb_cubic_bezier_point_evaluator.sv @@
// tb_cubic_bezier_point_evaluator: self-checking bench for the cubic Bezier point evaluator.
// Drives t beats and control point writes, predicts or hand-types each point, checks it.
// Depends on cbe_pkg and cubic_bezier_point_evaluator.
`timescale 1ns / 1ps

module tb_cubic_bezier_point_evaluator;
  import cbe_pkg::*;

  // pipeline depth of the cubic build: three stages per level plus output reg
  localparam int PIPE_LAT       = 3 * (NUM_POINTS_DEF - 1) + 1;
  localparam int RAND_PER_PHASE = 170;
  localparam int NUM_PHASES     = 6;
  // cycles in a row with no beat on any channel before we call it hung
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [T_W-1:0]     T_MAX     = '1;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // one input beat; known marks a row whose point is typed in by hand
  typedef struct {
    logic [T_W-1:0]     t;
    bit                 known;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } t_beat_t;

  // control point layouts used across phases
  typedef enum int {
    PAT_ZERO,
    PAT_FULL,
    PAT_ZIGZAG,
    PAT_RANDOM
  } ctrl_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [T_W-1:0]       in_param_t;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_point_x;
  logic [COORD_W-1:0]   out_point_y;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  // hand-typed expectation riding along with the driven t beat
  logic                 pinned_known;
  logic [COORD_W-1:0]   pinned_x;
  logic [COORD_W-1:0]   pinned_y;

  logic [COORD_W-1:0]   ctrl_pts [NUM_CTRL][2];   // [point][0 = x, 1 = y]
  point_t               pending_points[$];
  t_beat_t              directed_rows[$];
  int                   err_count   = 0;
  int                   idle_cycles = 0;
  int                   src_idle_pct = 0;
  int                   dst_idle_pct = 0;

  cubic_bezier_point_evaluator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_param_t (in_param_t),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bernstein form of the cubic, exact: weights u^3, 3tu^2, 3t^2u, t^3 sum to
  // 2^48, so the full sum fits in 64 bits and bits [59:48] are the pixel.
  // t above 1.0 clamps to 1.0.
  function automatic point_t bezier_point(input logic [T_W-1:0] t_raw);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] w [NUM_CTRL];
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    point_t      p;
    t = (t_raw > T_ONE) ? 64'(T_ONE) : 64'(t_raw);
    u = 64'(T_ONE) - t;
    w[0] = u * u * u;
    w[1] = 3 * t * u * u;
    w[2] = 3 * t * t * u;
    w[3] = t * t * t;
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NUM_CTRL; i++) begin
      sum_x += w[i] * 64'(ctrl_pts[i][0]);
      sum_y += w[i] * 64'(ctrl_pts[i][1]);
    end
    p.x = sum_x[3*FRAC_W +: COORD_W];
    p.y = sum_y[3*FRAC_W +: COORD_W];
    return p;
  endfunction

  // Receiver: random stall at the current percentage.
  always @(posedge clk) begin
    out_stall <= (dst_idle_pct != 0) && ($urandom_range(99) < dst_idle_pct);
  end

  // Scoreboard. Input beats push the expected point (typed row or predictor),
  // result beats pop and compare. Config only moves while drained, so the
  // control points seen here are the ones the block used.
  always @(posedge clk) begin
    point_t exp_pt;
    point_t new_pt;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_points.size() == 0) begin
          $error("unexpected result beat: x=%0d y=%0d", out_point_x, out_point_y);
          err_count++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (out_point_x !== exp_pt.x) begin
            $error("point_x mismatch: expected %0d, got %0d", exp_pt.x, out_point_x);
            err_count++;
          end
          if (out_point_y !== exp_pt.y) begin
            $error("point_y mismatch: expected %0d, got %0d", exp_pt.y, out_point_y);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (pinned_known) begin
          new_pt.x = pinned_x;
          new_pt.y = pinned_y;
        end else begin
          new_pt = bezier_point(in_param_t);
        end
        pending_points.push_back(new_pt);
      end
    end
  end

  // Watchdog: any accepted beat on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_pacing(input int src_pct, input int dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
  endtask

  // Sender: optional random gap, then hold the beat until it is taken.
  // Returns in the step of acceptance; in_valid stays high for a following beat.
  task automatic send_t(input t_beat_t b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_param_t   <= b.t;
    pinned_known <= b.known;
    pinned_x     <= b.x;
    pinned_y     <= b.y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need one assignment per step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_REGS)
      ctrl_pts[idx[2:1]][idx[0]] = val;
  endtask

  function automatic logic [COORD_W-1:0] COORD_WIDTH_RAND();
    return COORD_W'($urandom_range(COORD_MAX));
  endfunction

  // Write all eight coordinates per the pattern, then one junk write to an
  // index past the register file, which the block must drop.
  task automatic load_ctrl_points(input ctrl_pattern_t pat);
    logic [COORD_W-1:0] val;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (pat)
        PAT_ZERO:   val = '0;
        PAT_FULL:   val = COORD_MAX;
        // x swings low-high-high-low, y the opposite
        PAT_ZIGZAG: val = ((r / 2 == 0 || r / 2 == 3) ^ (r % 2 == 1)) ? '0 : COORD_MAX;
        default:    val = COORD_WIDTH_RAND();
      endcase
      write_reg(cfg_reg_t'(r), val);
    end
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_REGS)), COORD_WIDTH_RAND());
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range t, with pinned ends and a share past 1.0.
  function automatic t_beat_t random_t_beat();
    t_beat_t b;
    int      pick;
    pick    = $urandom_range(99);
    b.known = 1'b0;
    b.x     = '0;
    b.y     = '0;
    if (pick < 5)       b.t = '0;
    else if (pick < 10) b.t = T_ONE;
    else if (pick < 18) b.t = T_W'($urandom_range(T_MAX, T_ONE + 1));
    else                b.t = T_W'($urandom_range(T_ONE - 1));
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_param_t   <= '0;
    pinned_known <= 1'b0;
    pinned_x     <= '0;
    pinned_y     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    for (int i = 0; i < NUM_CTRL; i++) begin
      ctrl_pts[i][0] = CTRL_RST[i][0];
      ctrl_pts[i][1] = CTRL_RST[i][1];
    end

    // Directed rows on the reset control points (200,200) (400,400) (600,450)
    // (800,200). Ends and anything past 1.0 are typed in: t = 0 gives the
    // start point, t >= 1.0 the end point. The rest go to the predictor.
    directed_rows.push_back('{'0,             1'b1, 12'd200, 12'd200});
    directed_rows.push_back('{T_ONE,          1'b1, 12'd800, 12'd200});
    directed_rows.push_back('{T_ONE + 17'd1,  1'b1, 12'd800, 12'd200});
    directed_rows.push_back('{T_MAX,          1'b1, 12'd800, 12'd200});
    directed_rows.push_back('{17'h18000,      1'b1, 12'd800, 12'd200});
    directed_rows.push_back('{17'h15555,      1'b1, 12'd800, 12'd200});
    directed_rows.push_back('{17'h00001,      1'b0, '0, '0});
    directed_rows.push_back('{17'h00002,      1'b0, '0, '0});
    directed_rows.push_back('{17'h04000,      1'b0, '0, '0});
    directed_rows.push_back('{17'h08000,      1'b0, '0, '0});
    directed_rows.push_back('{17'h0C000,      1'b0, '0, '0});
    directed_rows.push_back('{17'h0FFFF,      1'b0, '0, '0});
    directed_rows.push_back('{17'h0AAAA,      1'b0, '0, '0});
    directed_rows.push_back('{17'h05555,      1'b0, '0, '0});
    directed_rows.push_back('{17'h0FF00,      1'b0, '0, '0});
    directed_rows.push_back('{17'h000FF,      1'b0, '0, '0});
    directed_rows.push_back('{17'h08001,      1'b0, '0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender sparse gaps, receiver heavy backpressure
    set_pacing(12, 53);
    foreach (directed_rows[i]) send_t(directed_rows[i]);
    in_valid <= 1'b0;

    // Random phases: each rewrites every control point while drained.
    // Pacing: two phases each of sender-light/receiver-heavy, swapped, none.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph / 2)
        0:       set_pacing(12, 53);
        1:       set_pacing(53, 12);
        default: set_pacing(0, 0);
      endcase
      case (ph)
        0:       load_ctrl_points(PAT_ZERO);
        1:       load_ctrl_points(PAT_FULL);
        2:       load_ctrl_points(PAT_ZIGZAG);
        default: load_ctrl_points(PAT_RANDOM);
      endcase
      @(posedge clk);
      for (int n = 0; n < RAND_PER_PHASE; n++) send_t(random_t_beat());
      in_valid <= 1'b0;
    end

    wait_drained();
    set_pacing(0, 0);
    // let any stray beat surface past the pipeline
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cbe_pkg.sv
design/cbe_lerp_level.sv
design/cubic_bezier_point_evaluator.sv
design/cbe_checker.sv
dv/tb_cubic_bezier_point_evaluator.sv
